// File: rtl/irfm_pkg.sv
// ----------------------------------------------------------------------------
// irfm_pkg
// Shared constants and types for the forward-mapping image rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package irfm_pkg;

  // largest source dimension and fraction bits of the trig values
  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 14;

  localparam int DIM_W      = $clog2(MAX_DIM);      // source row / column
  localparam int SRC_SIZE_W = DIM_W + 1;            // source size register
  localparam int DST_SIZE_W = DIM_W + 2;            // destination size register
  localparam int OUT_W      = DIM_W + 1;            // destination coordinate
  localparam int TRIG_W     = 16;                   // cosine / sine
  localparam int PIX_W      = 32;

  // centred offsets lie in -(MAX_DIM-1) .. MAX_DIM/2
  localparam int COORD_W = DIM_W + 1;
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W - FRAC_BITS + 1;
  localparam int DST_W   = RND_W + 1;

  localparam int IN_FIELDS_W  = 2 * DIM_W + PIX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * OUT_W + PIX_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = TRIG_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COS        = 3'd0,
    CFG_SIN        = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_DST_WIDTH  = 3'd4,
    CFG_DST_HEIGHT = 3'd5
  } cfg_index_t;

  localparam logic signed [TRIG_W-1:0]   COS_RESET  = TRIG_W'(1 << FRAC_BITS);
  localparam logic signed [TRIG_W-1:0]   SIN_RESET  = '0;
  localparam logic [SRC_SIZE_W-1:0]      SRC_LIMIT  = SRC_SIZE_W'(MAX_DIM);
  localparam logic [DST_SIZE_W-1:0]      DST_LIMIT  = DST_SIZE_W'(2 * MAX_DIM);
  localparam logic [SUM_W-1:0]           ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));

endpackage

`default_nettype wire

// File: rtl/image_rotate_forward_map.sv
// ----------------------------------------------------------------------------
// image_rotate_forward_map
// Nearest-neighbor forward rotation of one source pixel per word.
// ----------------------------------------------------------------------------
//  channel   dir  signals                               word
//  s_        in   s_tvalid s_tready s_tdata[55:0]       source pixel
//  m_        out  m_tvalid m_tready m_tdata[63:0]       rotated pixel
//  cfg_      in   cfg_valid cfg_ready cfg_index cfg_data register write
//
//  one pixel accepted per cycle while m_ does not stall; five register stages from input to output
//  (offsets, products, sums, rounding, destination check + output register)
//  pixels landing outside the destination are dropped at the output stage
//  a stall at m_ holds every occupied stage; empty stages still fill
//  rst clears the stage valids and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module image_rotate_forward_map (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // source word: src_row, src_col, pixel_value
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [irfm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // result word: dst_x, dst_y, pixel_out, zero pad
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [irfm_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [irfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [irfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DIM_W      = irfm_pkg::DIM_W;
  localparam int SRC_SIZE_W = irfm_pkg::SRC_SIZE_W;
  localparam int DST_SIZE_W = irfm_pkg::DST_SIZE_W;
  localparam int OUT_W      = irfm_pkg::OUT_W;
  localparam int TRIG_W     = irfm_pkg::TRIG_W;
  localparam int PIX_W      = irfm_pkg::PIX_W;
  localparam int COORD_W    = irfm_pkg::COORD_W;
  localparam int PROD_W     = irfm_pkg::PROD_W;
  localparam int SUM_W      = irfm_pkg::SUM_W;
  localparam int RND_W      = irfm_pkg::RND_W;
  localparam int DST_W      = irfm_pkg::DST_W;
  localparam int FRAC_BITS  = irfm_pkg::FRAC_BITS;
  localparam int PAD_W      = irfm_pkg::OUT_TDATA_W - irfm_pkg::OUT_FIELDS_W;

  // configuration registers
  logic signed [TRIG_W-1:0] cos_value;
  logic signed [TRIG_W-1:0] sin_value;
  logic [SRC_SIZE_W-1:0]    src_width;
  logic [SRC_SIZE_W-1:0]    src_height;
  logic [DST_SIZE_W-1:0]    dst_width;
  logic [DST_SIZE_W-1:0]    dst_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_value  <= irfm_pkg::COS_RESET;
      sin_value  <= irfm_pkg::SIN_RESET;
      src_width  <= irfm_pkg::SRC_LIMIT;
      src_height <= irfm_pkg::SRC_LIMIT;
      dst_width  <= irfm_pkg::DST_LIMIT;
      dst_height <= irfm_pkg::DST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (irfm_pkg::cfg_index_t'(cfg_index))
        irfm_pkg::CFG_COS:        cos_value  <= cfg_data;
        irfm_pkg::CFG_SIN:        sin_value  <= cfg_data;
        irfm_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_data[SRC_SIZE_W-1:0];
        irfm_pkg::CFG_SRC_HEIGHT: src_height <= cfg_data[SRC_SIZE_W-1:0];
        irfm_pkg::CFG_DST_WIDTH:  dst_width  <= cfg_data[DST_SIZE_W-1:0];
        irfm_pkg::CFG_DST_HEIGHT: dst_height <= cfg_data[DST_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes and centres; the user keeps them static while pixels flow, the block does not enforce it
  logic [SRC_SIZE_W-1:0]   w_clamp, h_clamp;
  logic [DST_SIZE_W-1:0]   wd_clamp, hd_clamp;
  logic [DIM_W-1:0]        half_w, half_h;      // floor(size/2) = size-1-centre
  logic [DST_SIZE_W-1:0]   wd_plus, hd_plus;
  logic signed [DST_W-1:0] cwd, chd;

  always_comb begin
    w_clamp  = (src_width  > irfm_pkg::SRC_LIMIT) ? irfm_pkg::SRC_LIMIT : src_width;
    h_clamp  = (src_height > irfm_pkg::SRC_LIMIT) ? irfm_pkg::SRC_LIMIT : src_height;
    wd_clamp = (dst_width  > irfm_pkg::DST_LIMIT) ? irfm_pkg::DST_LIMIT : dst_width;
    hd_clamp = (dst_height > irfm_pkg::DST_LIMIT) ? irfm_pkg::DST_LIMIT : dst_height;
    half_w   = w_clamp[SRC_SIZE_W-1:1];
    half_h   = h_clamp[SRC_SIZE_W-1:1];
    wd_plus  = (wd_clamp + DST_SIZE_W'(1)) >> 1;
    hd_plus  = (hd_clamp + DST_SIZE_W'(1)) >> 1;
    cwd      = DST_W'(signed'({1'b0, wd_plus})) - DST_W'(1);
    chd      = DST_W'(signed'({1'b0, hd_plus})) - DST_W'(1);
  end

  // stage handshake: a stage loads when it is empty or its successor loads
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, out_free;

  assign out_free = !m_tvalid || m_tready;
  assign rdy4     = !v4 || out_free;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // stage 1: mirrored, centred offsets
  logic [DIM_W-1:0]          in_row, in_col;
  logic [PIX_W-1:0]          in_pix;
  logic signed [COORD_W-1:0] x_next, y_next;
  logic signed [COORD_W-1:0] x1, y1;
  logic [PIX_W-1:0]          pix1;

  assign in_row = s_tdata[DIM_W-1:0];
  assign in_col = s_tdata[2*DIM_W-1:DIM_W];
  assign in_pix = s_tdata[2*DIM_W+PIX_W-1:2*DIM_W];
  assign x_next = signed'({1'b0, half_w}) - signed'({1'b0, in_col});
  assign y_next = signed'({1'b0, half_h}) - signed'({1'b0, in_row});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      x1   <= x_next;
      y1   <= y_next;
      pix1 <= in_pix;
    end
  end

  // stage 2: the four products
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic [PIX_W-1:0]         pix2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p_xc <= PROD_W'(x1) * PROD_W'(cos_value);
      p_ys <= PROD_W'(y1) * PROD_W'(sin_value);
      p_xs <= PROD_W'(x1) * PROD_W'(sin_value);
      p_yc <= PROD_W'(y1) * PROD_W'(cos_value);
      pix2 <= pix1;
    end
  end

  // stage 3: exact sums in fixed point
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [PIX_W-1:0]        pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sum_x <= SUM_W'(p_xc) + SUM_W'(p_ys);
      sum_y <= SUM_W'(p_yc) - SUM_W'(p_xs);
      pix3  <= pix2;
    end
  end

  // stage 4: round half away from zero on the magnitude
  logic [SUM_W-1:0]        mag_x, mag_y, rmag_x, rmag_y;
  logic signed [RND_W-1:0] r_x, r_y, xr_next, yr_next;
  logic signed [RND_W-1:0] xr, yr;
  logic [PIX_W-1:0]        pix4;

  always_comb begin
    mag_x   = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
    mag_y   = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
    rmag_x  = mag_x + irfm_pkg::ROUND_HALF;
    rmag_y  = mag_y + irfm_pkg::ROUND_HALF;
    r_x     = signed'({1'b0, rmag_x[SUM_W-1:FRAC_BITS]});
    r_y     = signed'({1'b0, rmag_y[SUM_W-1:FRAC_BITS]});
    xr_next = sum_x[SUM_W-1] ? -r_x : r_x;
    yr_next = sum_y[SUM_W-1] ? -r_y : r_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      xr   <= xr_next;
      yr   <= yr_next;
      pix4 <= pix3;
    end
  end

  // output stage: re-centre on the destination and keep only in-range pixels
  logic signed [DST_W-1:0] xf, yf;
  logic                    keep;
  logic [OUT_W-1:0]        dst_x, dst_y;
  logic [PIX_W-1:0]        pixel_out;

  always_comb begin
    xf   = cwd - DST_W'(xr);
    yf   = chd - DST_W'(yr);
    keep = !xf[DST_W-1] && !yf[DST_W-1]
        && (xf < DST_W'(signed'({1'b0, wd_clamp})))
        && (yf < DST_W'(signed'({1'b0, hd_clamp})));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= v4 && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v4 && keep) begin
      dst_x     <= xf[OUT_W-1:0];
      dst_y     <= yf[OUT_W-1:0];
      pixel_out <= pix4;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, pixel_out, dst_y, dst_x};

`ifndef SYNTH
  // every word shown lies inside the destination frame
  a_out_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (({1'b0, dst_x} < wd_clamp) && ({1'b0, dst_y} < hd_clamp)))
    else $error("result outside destination frame");

  // a new result only comes from an occupied rounding stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v4))
    else $error("result without a source item");

  // a blocked stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy4) |=> (v3 && $stable(sum_x) && $stable(sum_y)))
    else $error("stalled item lost or changed");
`endif

endmodule

`default_nettype wire
